@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL; sgrb_seq.sv is the file that includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

@@ rtl/sgrb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sgrb_pkg;

  localparam int GLYPH_SIDE = 8;
  localparam int SCALE      = 2;
  localparam int XVIS_N     = GLYPH_SIDE * SCALE;
  localparam int CAND_N     = GLYPH_SIDE * SCALE * SCALE;
  localparam int CAND_W     = $clog2(CAND_N);
  localparam int COL_W      = $clog2(GLYPH_SIDE);
  localparam int ROW_W      = $clog2(GLYPH_SIDE);
  localparam int ADDR_W     = 48;
  localparam int COLOR_W    = 32;
  localparam int SCREEN_W   = 16;
  localparam int PITCH_W    = 20;
  localparam int BPP_SHIFT  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DISPLAY_READY = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_ROW_PITCH     = 3'd3,
    REG_BASE_ADDRESS  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic                display_ready;
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [PITCH_W-1:0]  row_pitch;
    logic [ADDR_W-1:0]   base_address;
  } cfg_t;

  // One glyph row, ready for the write sequencer.
  typedef struct packed {
    logic [CAND_N-1:0]     mask;      // visible candidate pixels
    logic [CAND_W-1:0]     last_idx;  // highest visible candidate
    logic [ADDR_W-1:0]     addr0;     // address of (pen_x, y0)
    logic [ADDR_W-1:0]     addr1;     // address of (pen_x, y0 + 1)
    logic [GLYPH_SIDE-1:0] bits;
    logic [COLOR_W-1:0]    fg;
    logic [COLOR_W-1:0]    bg;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/sgrb_prep.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgrb_prep import sgrb_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [GLYPH_SIDE-1:0] in_bits,
  input  logic [ROW_W-1:0]      in_row,
  input  logic [COORD_BITS-1:0] in_px,
  input  logic [COORD_BITS-1:0] in_py,
  input  logic [COLOR_W-1:0]    in_fg,
  input  logic [COLOR_W-1:0]    in_bg,
  input  cfg_t                  cfg,
  output logic                  item_valid,
  output item_t                 item,
  input  logic                  item_ready
);

  localparam int XW     = COORD_BITS + 1;
  localparam int CW     = (XW > SCREEN_W) ? XW : SCREEN_W;
  localparam int PROD_W = XW + PITCH_W;
  localparam int PX4_W  = COORD_BITS + BPP_SHIFT;
  localparam int QW     = ((PX4_W > PITCH_W) ? PX4_W : PITCH_W) + 1;

  logic free1, free2, free3, free4, free5;

  // stage 1: captured transaction
  logic                  v1_r;
  logic [COORD_BITS-1:0] px1_r, py1_r;
  logic [ROW_W-1:0]      row1_r;
  logic [GLYPH_SIDE-1:0] bits1_r;
  logic [COLOR_W-1:0]    fg1_r, bg1_r;

  // stage 2: cell line and column clipping
  logic                  v2_r;
  logic [XW-1:0]         y0_2_r, y0_2_nxt;
  logic [XVIS_N-1:0]     xvis2_r, xvis2_nxt;
  logic [COORD_BITS-1:0] px2_r;
  logic [GLYPH_SIDE-1:0] bits2_r;
  logic [COLOR_W-1:0]    fg2_r, bg2_r;

  // stage 3: line offset product and candidate mask
  logic                  v3_r;
  logic [PROD_W-1:0]     yp3_r;
  logic [CAND_N-1:0]     mask3_r, mask3_nxt;
  logic [COORD_BITS-1:0] px3_r;
  logic [GLYPH_SIDE-1:0] bits3_r;
  logic [COLOR_W-1:0]    fg3_r, bg3_r;
  logic                  ylo_ok, yhi_ok;

  // stage 4: row base, last visible index
  logic                  v4_r;
  logic [ADDR_W-1:0]     s4_r;
  logic [PX4_W-1:0]      px4_r;
  logic [QW-1:0]         q4_r;
  logic [CAND_N-1:0]     mask4_r;
  logic [CAND_W-1:0]     last4_r, last4_nxt;
  logic                  any4_r;
  logic [GLYPH_SIDE-1:0] bits4_r;
  logic [COLOR_W-1:0]    fg4_r, bg4_r;

  // stage 5: final addresses
  logic                  v5_r;
  item_t                 item5_r;

  assign free5    = !v5_r || item_ready;
  assign free4    = !v4_r || free5;
  assign free3    = !v3_r || free4;
  assign free2    = !v2_r || free3;
  assign free1    = !v1_r || free2;
  assign in_ready = free1;

  assign item_valid = v5_r;
  assign item       = item5_r;

  always_comb begin
    y0_2_nxt = XW'(py1_r) + XW'({row1_r, 1'b0});
    for (int j = 0; j < XVIS_N; j++) begin
      xvis2_nxt[j] = CW'(XW'(px1_r) + XW'(j)) < CW'(cfg.screen_width);
    end
  end

  assign ylo_ok = CW'(y0_2_r) < CW'(cfg.screen_height);
  assign yhi_ok = CW'(y0_2_r + XW'(1)) < CW'(cfg.screen_height);

  // candidate k: column k/4, bit 0 picks x+1, bit 1 picks y+1
  always_comb begin
    for (int k = 0; k < CAND_N; k++) begin
      mask3_nxt[k] = cfg.display_ready
                     && xvis2_r[((k >> 2) << 1) + (k & 1)]
                     && (((k & 2) != 0) ? yhi_ok : ylo_ok);
    end
  end

  always_comb begin
    last4_nxt = '0;
    for (int k = 0; k < CAND_N; k++) begin
      if (mask3_r[k]) begin
        last4_nxt = CAND_W'(k);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (free1) v1_r <= in_valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free4) v4_r <= v3_r;
      // rows with nothing visible end here
      if (free5) v5_r <= v4_r && any4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (free1) begin
      px1_r   <= in_px;
      py1_r   <= in_py;
      row1_r  <= in_row;
      bits1_r <= in_bits;
      fg1_r   <= in_fg;
      bg1_r   <= in_bg;
    end
    if (free2) begin
      y0_2_r  <= y0_2_nxt;
      xvis2_r <= xvis2_nxt;
      px2_r   <= px1_r;
      bits2_r <= bits1_r;
      fg2_r   <= fg1_r;
      bg2_r   <= bg1_r;
    end
    if (free3) begin
      yp3_r   <= PROD_W'(y0_2_r) * PROD_W'(cfg.row_pitch);
      mask3_r <= mask3_nxt;
      px3_r   <= px2_r;
      bits3_r <= bits2_r;
      fg3_r   <= fg2_r;
      bg3_r   <= bg2_r;
    end
    if (free4) begin
      s4_r    <= cfg.base_address + ADDR_W'(yp3_r);
      px4_r   <= {px3_r, {BPP_SHIFT{1'b0}}};
      q4_r    <= QW'({px3_r, {BPP_SHIFT{1'b0}}}) + QW'(cfg.row_pitch);
      mask4_r <= mask3_r;
      last4_r <= last4_nxt;
      any4_r  <= |mask3_r;
      bits4_r <= bits3_r;
      fg4_r   <= fg3_r;
      bg4_r   <= bg3_r;
    end
    if (free5) begin
      item5_r.mask     <= mask4_r;
      item5_r.last_idx <= last4_r;
      item5_r.addr0    <= s4_r + ADDR_W'(px4_r);
      item5_r.addr1    <= s4_r + ADDR_W'(q4_r);
      item5_r.bits     <= bits4_r;
      item5_r.fg       <= fg4_r;
      item5_r.bg       <= bg4_r;
    end
  end

endmodule

`default_nettype wire

@@ rtl/sgrb_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sgrb_seq import sgrb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  item_t              item,
  output logic               item_ready,
  output logic               out_strobe,
  output logic [ADDR_W-1:0]  out_pixel_address,
  output logic [COLOR_W-1:0] out_pixel_color,
  output logic               out_last_write
);

  item_t               item_r;
  logic                active_r;
  logic [CAND_W-1:0]   cnt_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_last_r, out_last_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [COLOR_W-1:0]  color_r, color_nxt;
  logic                done, take;
  logic [COL_W-1:0]    col;
  logic [COL_W+2:0]    offs;

  assign done       = cnt_r == item_r.last_idx;
  assign item_ready = !active_r || done;
  assign take       = item_valid && item_ready;

  assign col  = cnt_r[CAND_W-1:2];
  // byte offset of column pixel 2*col + dx
  assign offs = {col, cnt_r[0], {BPP_SHIFT{1'b0}}};

  assign out_valid_nxt = active_r && item_r.mask[cnt_r];
  assign out_last_nxt  = active_r && done && item_r.mask[cnt_r];
  assign addr_nxt      = (cnt_r[1] ? item_r.addr1 : item_r.addr0) + ADDR_W'(offs);
  assign color_nxt     = item_r.bits[COL_W'(GLYPH_SIDE - 1) - col] ? item_r.fg : item_r.bg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      if (take) begin
        active_r <= 1'b1;
      end else if (done) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    color_r <= color_nxt;
    if (take) begin
      item_r <= item;
      cnt_r  <= '0;
    end else if (active_r) begin
      cnt_r <= cnt_r + CAND_W'(1);
    end
  end

  assign out_strobe        = out_valid_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_color   = color_r;
  assign out_last_write    = out_last_r;

  `ASSERT_CLK(a_cnt_bounded, clk, rst_n, active_r |-> (cnt_r <= item_r.last_idx), "candidate count ran past last visible pixel")
  `ASSERT_NEVER(a_last_no_strobe, clk, rst_n, out_last_r && !out_valid_r, "last_write without strobe")
  `ASSERT_CLK(a_end_restarts, clk, rst_n, (active_r && done) |=> (!active_r || cnt_r == '0), "row end did not restart the sequencer")
  `ASSERT_CLK(a_strobe_from_row, clk, rst_n, out_valid_r |-> $past(active_r), "strobe without an active row")

endmodule

`default_nettype wire

@@ rtl/scaled_glyph_row_blitter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Glyph row blitter: expands one 8-bit font row into 2x2 pixel blocks.
// Input: pulse start with the row fields; the transaction is taken on an edge
// where start is high and busy is low. busy only rises when the 5-stage
// front pipeline is full and the write sequencer is still emitting.
// Output: one pixel write per out_strobe cycle (address, color); out_last_write
// marks the final write of a row. The receiver cannot stall; writes come
// whenever they are ready. Rows with no visible pixel produce nothing.
// Path: an accepted row passes the five prep stages, is taken by the sequencer,
// and each candidate's write is registered onto the outputs. Throughput: the
// sequencer walks candidates 0..last visible (last_idx at most 31), one per
// cycle, and takes the next row as it finishes one; the single write port sets
// that rate. Rows with nothing visible cost no sequencer time.
// Config: cfg_write_en/cfg_index/cfg_data write a register at the edge; change
// registers only while idle. Unknown indexes are ignored.
// Reset (rst_n low, synchronous): all registers zero, so nothing is emitted
// until display_ready is set; the pipeline is emptied.

module scaled_glyph_row_blitter_core import sgrb_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [GLYPH_SIDE-1:0] in_glyph_bits,
  input  logic [ROW_W-1:0]      in_glyph_row,
  input  logic [COORD_BITS-1:0] in_pen_x,
  input  logic [COORD_BITS-1:0] in_pen_y,
  input  logic [COLOR_W-1:0]    in_foreground_color,
  input  logic [COLOR_W-1:0]    in_background_color,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  out_strobe,
  output logic [ADDR_W-1:0]     out_pixel_address,
  output logic [COLOR_W-1:0]    out_pixel_color,
  output logic                  out_last_write
);

  cfg_t  cfg_r;
  logic  prep_ready;
  logic  item_valid, item_ready;
  item_t item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_DISPLAY_READY: cfg_r.display_ready <= cfg_data[0];
        REG_SCREEN_WIDTH:  cfg_r.screen_width  <= cfg_data[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data[SCREEN_W-1:0];
        REG_ROW_PITCH:     cfg_r.row_pitch     <= cfg_data[PITCH_W-1:0];
        REG_BASE_ADDRESS:  cfg_r.base_address  <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = !prep_ready;

  sgrb_prep #(
    .COORD_BITS (COORD_BITS)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (start && prep_ready),
    .in_ready   (prep_ready),
    .in_bits    (in_glyph_bits),
    .in_row     (in_glyph_row),
    .in_px      (in_pen_x),
    .in_py      (in_pen_y),
    .in_fg      (in_foreground_color),
    .in_bg      (in_background_color),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_ready (item_ready)
  );

  sgrb_seq u_seq (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item_valid),
    .item              (item),
    .item_ready        (item_ready),
    .out_strobe        (out_strobe),
    .out_pixel_address (out_pixel_address),
    .out_pixel_color   (out_pixel_color),
    .out_last_write    (out_last_write)
  );

endmodule

`default_nettype wire

@@ bench/tb_scaled_glyph_row_blitter_core.sv @@
`timescale 1ns / 1ps

module tb_scaled_glyph_row_blitter_core;
  import sgrb_pkg::*;

  localparam int PEN_BITS     = 16;
  localparam int DRAIN_CYCLES = 16;
  localparam int STALL_LIMIT  = 2000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ROWS   = 55;

  typedef struct packed {
    logic [GLYPH_SIDE-1:0] bits;
    logic [ROW_W-1:0]      row;
    logic [PEN_BITS-1:0]   pen_x;
    logic [PEN_BITS-1:0]   pen_y;
    logic [COLOR_W-1:0]    fg;
    logic [COLOR_W-1:0]    bg;
  } glyph_row_t;

  localparam int ROW_BITS = $bits(glyph_row_t);

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_write_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [GLYPH_SIDE-1:0] in_glyph_bits = '0;
  logic [ROW_W-1:0] in_glyph_row = '0;
  logic [PEN_BITS-1:0] in_pen_x = '0;
  logic [PEN_BITS-1:0] in_pen_y = '0;
  logic [COLOR_W-1:0] in_foreground_color = '0;
  logic [COLOR_W-1:0] in_background_color = '0;
  logic cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic out_strobe;
  logic [ADDR_W-1:0] out_pixel_address;
  logic [COLOR_W-1:0] out_pixel_color;
  logic out_last_write;

  // register shadow
  logic                screen_on;
  logic [SCREEN_W-1:0] scr_width;
  logic [SCREEN_W-1:0] scr_height;
  logic [PITCH_W-1:0]  line_pitch;
  logic [ADDR_W-1:0]   fb_base;

  glyph_row_t   row_queue[$];
  pixel_write_t pending_writes[$];
  glyph_row_t   on_bus;

  int unsigned send_idle_pct = 30;
  int unsigned rows_taken = 0;
  int unsigned writes_checked = 0;
  int unsigned mismatches = 0;
  int unsigned settings_applied = 0;
  int unsigned stall_cycles = 0;

  scaled_glyph_row_blitter_core #(.COORD_BITS(PEN_BITS)) uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_glyph_bits       (in_glyph_bits),
    .in_glyph_row        (in_glyph_row),
    .in_pen_x            (in_pen_x),
    .in_pen_y            (in_pen_y),
    .in_foreground_color (in_foreground_color),
    .in_background_color (in_background_color),
    .cfg_write_en        (cfg_write_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .out_strobe          (out_strobe),
    .out_pixel_address   (out_pixel_address),
    .out_pixel_color     (out_pixel_color),
    .out_last_write      (out_last_write)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expand one row into its visible 2x2 pixel writes, in emit order.
  task automatic expand_glyph_row(input glyph_row_t r);
    logic [PEN_BITS:0] y0;
    logic [PEN_BITS:0] x;
    logic [PEN_BITS:0] y;
    logic [ADDR_W-1:0] addr;
    logic [COLOR_W-1:0] color;
    pixel_write_t held;
    bit have_held;
    have_held = 1'b0;
    held = '0;
    if (!screen_on) return;
    y0 = {1'b0, r.pen_y} + {r.row, 1'b0};
    for (int col = 0; col < GLYPH_SIDE; col++) begin
      color = r.bits[GLYPH_SIDE-1-col] ? r.fg : r.bg;
      for (int q = 0; q < 4; q++) begin
        x = {1'b0, r.pen_x} + (PEN_BITS+1)'(2 * col + q % 2);
        y = y0 + (PEN_BITS+1)'(q / 2);
        if (x < scr_width && y < scr_height) begin
          addr = fb_base + ADDR_W'(y) * ADDR_W'(line_pitch) + (ADDR_W'(x) << BPP_SHIFT);
          if (have_held) pending_writes.push_back(held);
          held = {addr, color, 1'b0};
          have_held = 1'b1;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_writes.push_back(held);
    end
  endtask

  task automatic queue_row(input logic [7:0] bits, input int row, input int px, input int py,
                           input logic [31:0] fg, input logic [31:0] bg);
    glyph_row_t r;
    r.bits = bits;
    r.row = ROW_W'(row);
    r.pen_x = PEN_BITS'(px);
    r.pen_y = PEN_BITS'(py);
    r.fg = fg;
    r.bg = bg;
    row_queue.push_back(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_DISPLAY_READY: screen_on = val[0];
      REG_SCREEN_WIDTH:  scr_width = val[SCREEN_W-1:0];
      REG_SCREEN_HEIGHT: scr_height = val[SCREEN_W-1:0];
      REG_ROW_PITCH:     line_pitch = val[PITCH_W-1:0];
      REG_BASE_ADDRESS:  fb_base = val[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [47:0] ready, input logic [47:0] w,
                               input logic [47:0] h, input logic [47:0] pitch,
                               input logic [47:0] base, input bit poke_unused);
    @(posedge clk);
    write_reg(REG_DISPLAY_READY, ready);
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_ROW_PITCH, pitch);
    write_reg(REG_BASE_ADDRESS, base);
    // indexes past the last register must be ignored
    if (poke_unused)
      for (int i = REG_BASE_ADDRESS + 1; i < 2 ** CFG_IDX_W; i++)
        write_reg(CFG_IDX_W'(i), CFG_DATA_W'({$urandom, $urandom}));
    cfg_write_en <= 1'b0;
    settings_applied++;
  endtask

  // checks run at negedge so queue and start updates of the edge have settled
  task automatic wait_idle();
    while (row_queue.size() != 0 || start || pending_writes.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_extent();
    case ($urandom_range(3))
      0: return 16'($urandom_range(1, 64));
      1: return 16'($urandom_range(65, 2048));
      2: return 16'($urandom);
      default: return 16'hFFFF;
    endcase
  endfunction

  always @(posedge clk) begin : row_driver
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expand_glyph_row(on_bus);
        rows_taken++;
      end
      if (!(start && busy)) begin
        if (row_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          on_bus = row_queue.pop_front();
          start <= 1'b1;
        end else begin
          // noise on the data lines while start is low
          on_bus = ROW_BITS'({$urandom, $urandom, $urandom, $urandom});
          start <= 1'b0;
        end
        in_glyph_bits <= on_bus.bits;
        in_glyph_row <= on_bus.row;
        in_pen_x <= on_bus.pen_x;
        in_pen_y <= on_bus.pen_y;
        in_foreground_color <= on_bus.fg;
        in_background_color <= on_bus.bg;
      end
    end
  end

  always @(posedge clk) begin : write_monitor
    pixel_write_t got;
    pixel_write_t want;
    got = {out_pixel_address, out_pixel_color, out_last_write};
    if (rst_n && out_strobe) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected write addr=%h color=%h last=%b", $realtime,
                   got.addr, got.color, got.last);
      end else begin
        want = pending_writes.pop_front();
        writes_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: write differs: exp addr=%h color=%h last=%b, got addr=%h color=%h last=%b",
                     $realtime, want.addr, want.color, want.last,
                     got.addr, got.color, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_strobe || cfg_write_en)
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("scaled_glyph_row_blitter_core: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] w;
    logic [15:0] h;
    int unsigned lim_x;
    int unsigned lim_y;
    int unsigned px;
    int unsigned py;
    screen_on = 1'b0;
    scr_width = '0;
    scr_height = '0;
    line_pitch = '0;
    fb_base = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: display off, nothing may come out
    queue_row(8'hFF, 0, 0, 0, 32'hFFFF_FFFF, 32'h0);
    queue_row(8'h00, 7, 65535, 65535, 32'h0, 32'hFFFF_FFFF);
    wait_idle();

    apply_setting(48'd1, 48'd640, 48'd480, 48'd2560, 48'h0000_1000_0000, 1'b1);
    queue_row(8'hFF, 0, 0, 0, 32'hFFFF_FFFF, 32'h0);
    queue_row(8'h00, 7, 0, 0, 32'h0, 32'hFFFF_FFFF);
    queue_row(8'hA5, 3, 100, 50, $urandom, $urandom);
    queue_row(8'h5A, 5, 636, 100, $urandom, $urandom);      // right edge clip
    queue_row(8'h80, 7, 10, 465, $urandom, $urandom);       // bottom line clip
    queue_row(8'h01, 0, 65535, 0, $urandom, $urandom);      // fully off to the right
    queue_row(8'h3C, 2, 0, 65535, $urandom, $urandom);      // fully off below
    queue_row(8'h0F, 6, 639, 467, $urandom, $urandom);      // one pixel in the corner
    wait_idle();

    // zero width, then zero height
    apply_setting(48'd1, 48'd0, 48'd480, 48'd2560, 48'd0, 1'b0);
    queue_row(8'hFF, 0, 0, 0, $urandom, $urandom);
    wait_idle();
    apply_setting(48'd1, 48'd640, 48'd0, 48'd2560, 48'd0, 1'b0);
    queue_row(8'hFF, 0, 0, 0, $urandom, $urandom);
    wait_idle();

    // largest registers: address wraps, coordinates clip at the top end
    apply_setting(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                  48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0);
    queue_row(8'hFF, 7, 65535, 65535, 32'hFFFF_FFFF, 32'h0);
    queue_row(8'hE7, 0, 65520, 65533, $urandom, $urandom);
    queue_row(8'hAA, 0, 65535, 0, $urandom, $urandom);
    queue_row(8'h55, 1, 0, 0, $urandom, $urandom);
    queue_row(8'hC3, 4, 32768, 32768, $urandom, $urandom);
    wait_idle();

    apply_setting(48'd1, 48'd1, 48'd1, 48'd0, 48'd0, 1'b0);
    queue_row(8'hFF, 0, 0, 0, $urandom, $urandom);
    queue_row(8'h7F, 0, 0, 0, $urandom, $urandom);
    wait_idle();

    // display off with a valid screen
    apply_setting(48'hFFFF_FFFF_FFFE, 48'd640, 48'd480, 48'd2560, 48'd0, 1'b0);
    queue_row(8'hFF, 3, 0, 0, $urandom, $urandom);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      send_idle_pct = (ph < 3) ? 30 : (ph < 6) ? 46 : 0;
      w = pick_extent();
      h = pick_extent();
      apply_setting({$urandom, 15'($urandom), 1'($urandom_range(7) != 0)},
                    {32'($urandom), w}, {32'($urandom), h},
                    48'({$urandom, $urandom}), 48'({$urandom, $urandom}), ph % 3 == 0);
      lim_x = (scr_width > 16'd65520) ? 65535 : scr_width + 15;
      lim_y = (scr_height > 16'd65520) ? 65535 : scr_height + 15;
      for (int n = 0; n < PHASE_ROWS; n++) begin
        // mostly near the visible area, some anywhere
        px = ($urandom_range(4) != 0) ? $urandom_range(0, lim_x) : $urandom;
        py = ($urandom_range(4) != 0) ? $urandom_range(0, lim_y) : $urandom;
        queue_row(8'($urandom), $urandom_range(7), px, py, $urandom, $urandom);
      end
      wait_idle();
    end

    $display("covered %0d register settings and %0d glyph rows", settings_applied, rows_taken);
    $display("%0d pixel writes checked, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0 && pending_writes.size() == 0)
      $display("scaled_glyph_row_blitter_core: match");
    else
      $display("scaled_glyph_row_blitter_core: mismatch");
    $finish;
  end

endmodule

@@ scaled_glyph_row_blitter_core.f @@
+incdir+rtl
rtl/sgrb_pkg.sv
rtl/sgrb_prep.sv
rtl/sgrb_seq.sv
rtl/scaled_glyph_row_blitter_core.sv
bench/tb_scaled_glyph_row_blitter_core.sv
